// ----- design/nbm_pkg.sv -----
// ----------------------------------------------------------------------------
// Nonlinear bit mix package
// Shared widths, stream packing constants and the item record that moves
// from cell to cell along the mixing chain.
// ----------------------------------------------------------------------------
package nbm_pkg;

    // Word width of the data and key words; one cell per bit.
    localparam int WIDTH = 41;

    // Stream data widths, rounded up to whole bytes.
    localparam int IN_TDATA_W  = ((2 * WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((WIDTH + 7) / 8) * 8;

    // Operation codes carried in the input tuser.
    localparam logic OP_MIX   = 1'b0;
    localparam logic OP_UNMIX = 1'b1;

    typedef logic [WIDTH-1:0] word_t;

    // One item in flight. The data and key words shift right by one bit per
    // cell, so every cell works on bit zero; result bits shift in at the top.
    typedef struct packed {
        logic  opcode;
        word_t data;
        word_t key;
        word_t res;
        logic  xp1;  // data bit i-1
        logic  xp2;  // data bit i-2
        logic  rp1;  // key bit i-1
        logic  rp2;  // key bit i-2
        logic  par;  // XOR of x[j] & r[j] for j < i
    } mix_item_t;

endpackage

// ----- design/nbm_cell.sv -----
// ----------------------------------------------------------------------------
// Nonlinear bit mix cell
// Handles one bit position of an item, then hands the item to the next cell
// through a registered stage with its own valid/ready handshake.
// ----------------------------------------------------------------------------
module nbm_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  nbm_pkg::mix_item_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output nbm_pkg::mix_item_t out_item
);

    logic               valid_reg;
    logic               valid_next;
    nbm_pkg::mix_item_t item_reg;
    nbm_pkg::mix_item_t item_next;

    logic s_bit;
    logic r_bit;
    logic c_bit;
    logic o_bit;
    logic x_bit;

    // The stage takes a new item when it is empty or its item moves on.
    assign in_ready = !valid_reg || out_ready;

    // Bit step: carry term from the two previous bits and the running parity.
    always_comb begin
        s_bit = in_item.data[0];
        r_bit = in_item.key[0];
        c_bit = (in_item.xp2 & in_item.xp1) ^ (in_item.rp2 & in_item.rp1) ^ in_item.par;
        o_bit = s_bit ^ r_bit ^ c_bit;
        x_bit = (in_item.opcode == nbm_pkg::OP_UNMIX) ? o_bit : s_bit;

        item_next        = in_item;
        item_next.data   = in_item.data >> 1;
        item_next.key    = in_item.key >> 1;
        item_next.res    = {o_bit, in_item.res[nbm_pkg::WIDTH-1:1]};
        item_next.par    = in_item.par ^ (x_bit & r_bit);
        item_next.xp2    = in_item.xp1;
        item_next.xp1    = x_bit;
        item_next.rp2    = in_item.rp1;
        item_next.rp1    = r_bit;
    end

    // Valid flag of the stage.
    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, loaded on each transfer into the stage.
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ----- design/nonlinear_bit_mix_and_unmix_core.sv -----
// ----------------------------------------------------------------------------
// Nonlinear bit mix and unmix core
// An input transfer passes through all WIDTH cell registers before its result appears.
// Throughput: one item per cycle while the result side takes items; each of the WIDTH cells is a register stage.
// Stalls on the result side fill empty stages first, then stop the input.
// Reset (aresetn low, synchronous) empties every stage; the payload registers are not reset.
// ----------------------------------------------------------------------------
module nonlinear_bit_mix_and_unmix_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [nbm_pkg::IN_TDATA_W-1:0]   s_tdata,  // data_in, key, zero fill
    input  logic                             s_tuser,  // opcode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [nbm_pkg::OUT_TDATA_W-1:0]  m_tdata   // data_out, zero fill
);

    logic               valid_chain [nbm_pkg::WIDTH+1];
    logic               ready_chain [nbm_pkg::WIDTH+1];
    nbm_pkg::mix_item_t item_chain  [nbm_pkg::WIDTH+1];

    // Unpack the input transfer into a fresh item with cleared carry history.
    always_comb begin
        item_chain[0]        = '0;
        item_chain[0].opcode = s_tuser;
        item_chain[0].data   = s_tdata[nbm_pkg::WIDTH-1:0];
        item_chain[0].key    = s_tdata[2*nbm_pkg::WIDTH-1:nbm_pkg::WIDTH];
    end

    assign valid_chain[0] = s_tvalid;
    assign s_tready       = ready_chain[0];

    // Row of identical cells, one per bit position.
    for (genvar i = 0; i < nbm_pkg::WIDTH; i++) begin : g_cell
        nbm_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_chain[i]),
            .in_ready  (ready_chain[i]),
            .in_item   (item_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_ready (ready_chain[i+1]),
            .out_item  (item_chain[i+1])
        );
    end

    // The last cell drives the result channel directly.
    assign m_tvalid                       = valid_chain[nbm_pkg::WIDTH];
    assign ready_chain[nbm_pkg::WIDTH]    = m_tready;
    assign m_tdata = nbm_pkg::OUT_TDATA_W'(item_chain[nbm_pkg::WIDTH].res);

endmodule

// ----- design/nbm_checker.sv -----
// ----------------------------------------------------------------------------
// Nonlinear bit mix port checker
// Watches the ports of the core for handshake, reset and packing errors.
// ----------------------------------------------------------------------------
module nbm_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [nbm_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its data.
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // Fill bits above the word are always zero.
    a_zero_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata >> nbm_pkg::WIDTH) == '0))
        else $error("nonzero fill bits in result");

    // Reset empties the chain.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // After reset every stage is empty, so the input is ready.
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready right after reset");

endmodule

bind nonlinear_bit_mix_and_unmix_core nbm_checker u_nbm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/sv/nonlinear_bit_mix_and_unmix_core_checker.sv -----
// ----------------------------------------------------------------------------
// Nonlinear bit mix and unmix checker
// Watches both stream channels of the core. For every input transfer it
// computes the mixed or unmixed word and queues it. Each output transfer is
// compared in order against the oldest queued word. It reports the mismatch
// count and the number of words still due to the test top.
// ----------------------------------------------------------------------------
module nonlinear_bit_mix_and_unmix_core_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [nbm_pkg::IN_TDATA_W-1:0]   s_tdata,   // data_in, key, zero fill
    input  logic                             s_tuser,   // opcode
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [nbm_pkg::OUT_TDATA_W-1:0]  m_tdata,   // data_out, zero fill
    output int                               words_due,
    output int                               n_fail
);

    // Words that the core still owes, oldest first.
    nbm_pkg::word_t mixed_due[$];

    // Walk the word from bit 0 upward with the carry-like term. For the
    // inverse, the data bits fed into the carry are the recovered ones.
    function automatic nbm_pkg::word_t mix_bits(input logic op,
                                                input nbm_pkg::word_t src,
                                                input nbm_pkg::word_t key);
        nbm_pkg::word_t res;
        logic  xp1, xp2, rp1, rp2, par, cy, o, x;
        res = '0;
        xp1 = 1'b0;
        xp2 = 1'b0;
        rp1 = 1'b0;
        rp2 = 1'b0;
        par = 1'b0;
        for (int i = 0; i < nbm_pkg::WIDTH; i++) begin
            cy = (xp2 & xp1) ^ (rp2 & rp1) ^ par;
            o  = src[i] ^ key[i] ^ cy;
            x  = (op == nbm_pkg::OP_UNMIX) ? o : src[i];
            res[i] = o;
            par = par ^ (x & key[i]);
            xp2 = xp1;
            xp1 = x;
            rp2 = rp1;
            rp1 = key[i];
        end
        return res;
    endfunction

    // Queue a prediction per input transfer, check each output transfer.
    always @(posedge aclk) begin : watch
        logic [nbm_pkg::OUT_TDATA_W-1:0] want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                mixed_due.push_back(mix_bits(s_tuser, s_tdata[nbm_pkg::WIDTH-1:0],
                                             s_tdata[2*nbm_pkg::WIDTH-1:nbm_pkg::WIDTH]));
            end
            if (m_tvalid && m_tready) begin
                if (mixed_due.size() == 0) begin
                    $display("%0t: unexpected output transfer, data_out %h",
                             $time, m_tdata);
                    n_fail <= n_fail + 1;
                end else begin
                    want = '0;
                    want[nbm_pkg::WIDTH-1:0] = mixed_due.pop_front();
                    if (m_tdata !== want) begin
                        $display("%0t: data_out mismatch, expected %h, actual %h",
                                 $time, want, m_tdata);
                        n_fail <= n_fail + 1;
                    end
                end
            end
        end
        words_due <= mixed_due.size();
    end

endmodule

// ----- tb/sv/nonlinear_bit_mix_and_unmix_core_test.sv -----
// ----------------------------------------------------------------------------
// Nonlinear bit mix and unmix core test
// Drives directed and random mix and unmix words into the core with random
// gaps on both channels, a long output hold-off that backs up the pipeline,
// and a pause that drains it. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module nonlinear_bit_mix_and_unmix_core_test;

    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_WAIT  = nbm_pkg::WIDTH + 20;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [nbm_pkg::IN_TDATA_W-1:0]   s_tdata;   // data_in, key, zero fill
    logic                             s_tuser;   // opcode
    logic                             m_tvalid;
    logic                             m_tready;
    logic [nbm_pkg::OUT_TDATA_W-1:0]  m_tdata;   // data_out, zero fill

    int words_due;
    int n_fail;
    int stall_cycles;
    int holds_asked;
    int holds_done;
    bit gaps_on;

    nonlinear_bit_mix_and_unmix_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    nonlinear_bit_mix_and_unmix_core_checker i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .words_due (words_due),
        .n_fail    (n_fail)
    );

    // Clock with a period of two time units.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Output side: random back-pressure, plus a long hold-off on request.
    initial begin : rx_side
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_asked != holds_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds_done++;
            end else if (gaps_on) begin
                m_tready <= ($urandom_range(99) >= 13);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Give up when nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("nonlinear_bit_mix_and_unmix_core_test failed");
            $finish;
        end
    end

    // Random word with a bias toward sparse, dense and single-bit patterns.
    function automatic nbm_pkg::word_t pick_word();
        logic [63:0]    raw_a, raw_b;
        nbm_pkg::word_t w;
        raw_a = {$urandom, $urandom};
        raw_b = {$urandom, $urandom};
        case ($urandom_range(7))
            1: w = raw_a[nbm_pkg::WIDTH-1:0] & raw_b[nbm_pkg::WIDTH-1:0]
                   & nbm_pkg::word_t'($urandom);
            2: w = raw_a[nbm_pkg::WIDTH-1:0] | raw_b[nbm_pkg::WIDTH-1:0];
            3: w = nbm_pkg::word_t'(1) << $urandom_range(nbm_pkg::WIDTH - 1);
            4: w = ~(nbm_pkg::word_t'(1) << $urandom_range(nbm_pkg::WIDTH - 1));
            5: w = raw_a[0] ? '1 : '0;
            default: w = raw_a[nbm_pkg::WIDTH-1:0];
        endcase
        return w;
    endfunction

    // Offer one word and wait for its transfer; may leave a one-cycle gap first.
    task automatic send_word(input logic op, input nbm_pkg::word_t data,
                             input nbm_pkg::word_t key);
        logic [nbm_pkg::IN_TDATA_W-1:0] beat;
        beat = '0;
        beat[nbm_pkg::WIDTH-1:0] = data;
        beat[2*nbm_pkg::WIDTH-1:nbm_pkg::WIDTH] = key;
        if (gaps_on && $urandom_range(99) < 15) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++) begin
            send_word($urandom_range(1) ? nbm_pkg::OP_UNMIX : nbm_pkg::OP_MIX,
                      pick_word(), pick_word());
        end
    endtask

    // Stop offering and wait until the core has returned every word.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (words_due != 0);
    endtask

    initial begin : stimulus
        nbm_pkg::word_t edge_data[8];
        nbm_pkg::word_t edge_key[8];
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= nbm_pkg::OP_MIX;
        aresetn     <= 1'b0;
        gaps_on     = 1'b1;
        holds_asked = 0;
        holds_done  = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Extremes: zeros, ones, alternating bits and the end bits alone.
        edge_data = '{'0, '1, '0, '1,
                      nbm_pkg::word_t'({21{2'b01}}), nbm_pkg::word_t'({21{2'b10}}),
                      nbm_pkg::word_t'(1) << (nbm_pkg::WIDTH - 1), nbm_pkg::word_t'(1)};
        edge_key  = '{'0, '0, '1, '1,
                      nbm_pkg::word_t'({21{2'b10}}), nbm_pkg::word_t'({21{2'b10}}),
                      nbm_pkg::word_t'(1), nbm_pkg::word_t'(1) << (nbm_pkg::WIDTH - 1)};
        for (int n = 0; n < 8; n++) begin
            send_word(nbm_pkg::OP_MIX, edge_data[n], edge_key[n]);
            send_word(nbm_pkg::OP_UNMIX, edge_data[n], edge_key[n]);
        end

        send_random(600);

        // Hold the output off while input keeps coming, so the core backs up.
        gaps_on = 1'b0;
        holds_asked++;
        send_random(150);
        drain();

        // A long run with no gaps on either side.
        send_random(500);

        gaps_on = 1'b1;
        send_random(750);

        drain();
        repeat (SETTLE_WAIT) @(posedge aclk);
        if (n_fail == 0) begin
            $display("nonlinear_bit_mix_and_unmix_core_test passed");
        end else begin
            $display("nonlinear_bit_mix_and_unmix_core_test failed");
        end
        $finish;
    end

endmodule
